### rtl/mwm_pkg.sv
// Shared types and constants for the mecanum wheel mixer.
// No dependencies; used by every module of the mixer.
package mwm_pkg;

   localparam int RATE_W  = 16;               // Q2.14 rate inputs
   localparam int WHEEL_W = RATE_W + 2;       // sum of three rates
   localparam int MAG_W   = WHEEL_W - 1;      // wheel magnitude, up to 3 * 2^15
   localparam int SPEED_W = 16;               // top_speed register
   localparam int QUO_W   = SPEED_W;          // scaled magnitude never exceeds top_speed
   localparam int DRIVE_W = QUO_W + 1;        // signed drive output
   localparam int PROD_W  = MAG_W + SPEED_W;  // magnitude times top_speed
   localparam int WHEELS  = 4;
   localparam int STEP_W  = $clog2(QUO_W);    // divider step counter
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W  = $clog2(QUEUE_DEPTH);

   localparam logic [SPEED_W-1:0] TOP_SPEED_RESET = 16'd255;

   // wheel order: front left, rear left, front right, rear right
   localparam int FL = 0;
   localparam int RL = 1;
   localparam int FR = 2;
   localparam int RR = 3;

   typedef logic [MAG_W-1:0] mag_type;

   // one classified command waiting for the back end
   typedef struct packed {
      mag_type [WHEELS-1:0] mag;
      logic [WHEELS-1:0]    neg;
      mag_type              peak;
      logic                 scaled;
   } entry_type;

endpackage

### rtl/mwm_front.sv
// Front end: forms the four wheel sums, their magnitudes and the peak,
// and decides whether normalisation is needed. Uses mwm_pkg.
module mwm_front #(
   parameter int FRAC_BITS = 14
) (
   input  logic signed [mwm_pkg::RATE_W-1:0] forward_rate,
   input  logic signed [mwm_pkg::RATE_W-1:0] strafe_rate,
   input  logic signed [mwm_pkg::RATE_W-1:0] turn_rate,
   output mwm_pkg::entry_type                entry
);

   localparam logic [31:0] ONE = 32'd1 << FRAC_BITS;

   logic signed [mwm_pkg::WHEEL_W-1:0] f_ext, s_ext, t_ext;
   logic signed [mwm_pkg::WHEEL_W-1:0] wheel [mwm_pkg::WHEELS];
   mwm_pkg::mag_type                   mag   [mwm_pkg::WHEELS];
   mwm_pkg::mag_type                   max_left, max_right, peak;

   always_comb begin
      f_ext = mwm_pkg::WHEEL_W'(forward_rate);
      s_ext = mwm_pkg::WHEEL_W'(strafe_rate);
      t_ext = mwm_pkg::WHEEL_W'(turn_rate);

      wheel[mwm_pkg::FL] = f_ext - s_ext + t_ext;
      wheel[mwm_pkg::RL] = f_ext + s_ext + t_ext;
      wheel[mwm_pkg::FR] = f_ext + s_ext - t_ext;
      wheel[mwm_pkg::RR] = f_ext - s_ext - t_ext;

      for (int i = 0; i < mwm_pkg::WHEELS; i++) begin
         mag[i] = wheel[i][mwm_pkg::WHEEL_W-1] ? mwm_pkg::MAG_W'(-wheel[i])
                                               : mwm_pkg::MAG_W'(wheel[i]);
         entry.mag[i] = mag[i];
         entry.neg[i] = wheel[i][mwm_pkg::WHEEL_W-1];
      end

      max_left  = (mag[0] > mag[1]) ? mag[0] : mag[1];
      max_right = (mag[2] > mag[3]) ? mag[2] : mag[3];
      peak      = (max_left > max_right) ? max_left : max_right;

      entry.peak   = peak;
      entry.scaled = {{(32 - mwm_pkg::MAG_W){1'b0}}, peak} > ONE;
   end

endmodule

### rtl/mwm_queue.sv
// Two-entry item queue between the front and back ends.
// Uses mwm_pkg for the entry type.
module mwm_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_valid,
   output logic               push_ready,
   input  mwm_pkg::entry_type push_entry,
   output logic               pop_valid,
   input  logic               pop_ready,
   output mwm_pkg::entry_type pop_entry
);

   mwm_pkg::entry_type                slot_ff [mwm_pkg::QUEUE_DEPTH];
   logic [mwm_pkg::QPTR_W-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [mwm_pkg::QPTR_W-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [mwm_pkg::QPTR_W:0]          count_ff, count_in;
   logic                              push, pop;

   assign push_ready = count_ff != (mwm_pkg::QPTR_W + 1)'(mwm_pkg::QUEUE_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_entry  = slot_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

### rtl/mwm_back.sv
// Back end: scales each wheel by top_speed, divides by the peak when
// normalising (four restoring lanes, one quotient bit per cycle) and holds
// the result in an output register. Uses mwm_pkg.
module mwm_back #(
   parameter int FRAC_BITS = 14
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [mwm_pkg::SPEED_W-1:0]         top_speed,
   input  logic                                item_valid,
   output logic                                item_ready,
   input  mwm_pkg::entry_type                  item,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [mwm_pkg::DRIVE_W-1:0]  rsp_front_left_drive,
   output logic signed [mwm_pkg::DRIVE_W-1:0]  rsp_rear_left_drive,
   output logic signed [mwm_pkg::DRIVE_W-1:0]  rsp_front_right_drive,
   output logic signed [mwm_pkg::DRIVE_W-1:0]  rsp_rear_right_drive,
   output logic                                rsp_was_scaled
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MUL,
      ST_DIV,
      ST_OUT
   } state_type;

   state_type                          state_ff, state_in;
   mwm_pkg::entry_type                 work_ff, work_in;
   logic [mwm_pkg::MAG_W-1:0]          rem_ff  [mwm_pkg::WHEELS];
   logic [mwm_pkg::MAG_W-1:0]          rem_in  [mwm_pkg::WHEELS];
   logic [mwm_pkg::QUO_W-1:0]          low_ff  [mwm_pkg::WHEELS];
   logic [mwm_pkg::QUO_W-1:0]          low_in  [mwm_pkg::WHEELS];
   logic [mwm_pkg::STEP_W-1:0]         step_ff, step_in;
   logic                               valid_ff, valid_in;
   logic [mwm_pkg::DRIVE_W-1:0]        drive_ff [mwm_pkg::WHEELS];
   logic [mwm_pkg::DRIVE_W-1:0]        drive_in [mwm_pkg::WHEELS];
   logic                               scaled_ff, scaled_in;

   logic [mwm_pkg::PROD_W-1:0]         prod    [mwm_pkg::WHEELS];
   logic [mwm_pkg::PROD_W-1:0]         shifted [mwm_pkg::WHEELS];
   logic [mwm_pkg::MAG_W:0]            trial   [mwm_pkg::WHEELS];
   logic                               take;

   assign item_ready = state_ff == ST_IDLE;
   assign take       = item_valid && item_ready;

   always_comb begin
      state_in  = state_ff;
      work_in   = work_ff;
      step_in   = step_ff;
      valid_in  = valid_ff && !rsp_ready;
      scaled_in = scaled_ff;
      for (int i = 0; i < mwm_pkg::WHEELS; i++) begin
         rem_in[i]   = rem_ff[i];
         low_in[i]   = low_ff[i];
         drive_in[i] = drive_ff[i];
         prod[i]     = {{mwm_pkg::SPEED_W{1'b0}}, work_ff.mag[i]} *
                       {{mwm_pkg::MAG_W{1'b0}}, top_speed};
         shifted[i]  = prod[i] >> FRAC_BITS;
         trial[i]    = {rem_ff[i], low_ff[i][mwm_pkg::QUO_W-1]};
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (take) begin
               work_in  = item;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            step_in = '0;
            for (int i = 0; i < mwm_pkg::WHEELS; i++) begin
               if (work_ff.scaled) begin
                  // quotient fits QUO_W bits, so the top part is already below the peak
                  rem_in[i] = prod[i][mwm_pkg::PROD_W-1:mwm_pkg::QUO_W];
                  low_in[i] = prod[i][mwm_pkg::QUO_W-1:0];
               end else begin
                  low_in[i] = shifted[i][mwm_pkg::QUO_W-1:0];
               end
            end
            state_in = work_ff.scaled ? ST_DIV : ST_OUT;
         end
         ST_DIV: begin
            for (int i = 0; i < mwm_pkg::WHEELS; i++) begin
               if (trial[i] >= {1'b0, work_ff.peak}) begin
                  rem_in[i] = mwm_pkg::MAG_W'(trial[i] - {1'b0, work_ff.peak});
                  low_in[i] = {low_ff[i][mwm_pkg::QUO_W-2:0], 1'b1};
               end else begin
                  rem_in[i] = trial[i][mwm_pkg::MAG_W-1:0];
                  low_in[i] = {low_ff[i][mwm_pkg::QUO_W-2:0], 1'b0};
               end
            end
            step_in = step_ff + 1'b1;
            if (step_ff == mwm_pkg::STEP_W'(mwm_pkg::QUO_W - 1)) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!valid_ff || rsp_ready) begin
               for (int i = 0; i < mwm_pkg::WHEELS; i++) begin
                  drive_in[i] = work_ff.neg[i] ? -{1'b0, low_ff[i]} : {1'b0, low_ff[i]};
               end
               scaled_in = work_ff.scaled;
               valid_in  = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
      work_ff   <= work_in;
      step_ff   <= step_in;
      scaled_ff <= scaled_in;
      for (int i = 0; i < mwm_pkg::WHEELS; i++) begin
         rem_ff[i]   <= rem_in[i];
         low_ff[i]   <= low_in[i];
         drive_ff[i] <= drive_in[i];
      end
   end

   assign rsp_valid             = valid_ff;
   assign rsp_front_left_drive  = drive_ff[mwm_pkg::FL];
   assign rsp_rear_left_drive   = drive_ff[mwm_pkg::RL];
   assign rsp_front_right_drive = drive_ff[mwm_pkg::FR];
   assign rsp_rear_right_drive  = drive_ff[mwm_pkg::RR];
   assign rsp_was_scaled        = scaled_ff;

endmodule

### rtl/mecanum_wheel_mixer_core.sv
// Mecanum X-drive wheel mixer, top level.
// Instantiates mwm_front, mwm_queue and mwm_back; uses mwm_pkg.

// Takes forward, strafe and turn rates in signed fixed point (1.0 is
// 2^FRAC_BITS) and returns four wheel drives in motor units, ordered front
// left, rear left, front right, rear right, plus a flag set when the largest
// wheel exceeded full scale and all wheels were divided by it. Each drive is
// wheel * top_speed / max(peak, 1.0), truncated toward zero. In the back end an
// item passes the idle, multiply and output states when no normalisation is
// needed, plus a divide state when it is, in which the four-lane restoring
// divider produces one quotient bit per cycle. A two-entry queue and an output
// register let new items be accepted while the back end is busy or a result
// waits. top_speed resets to 255 and is written through csr_wr_en/csr_wr_data.
module mecanum_wheel_mixer_core #(
   parameter int FRAC_BITS = 14
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wr_en,
   input  logic [mwm_pkg::SPEED_W-1:0]         csr_wr_data,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [mwm_pkg::RATE_W-1:0]   req_forward_rate,
   input  logic signed [mwm_pkg::RATE_W-1:0]   req_strafe_rate,
   input  logic signed [mwm_pkg::RATE_W-1:0]   req_turn_rate,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [mwm_pkg::DRIVE_W-1:0]  rsp_front_left_drive,
   output logic signed [mwm_pkg::DRIVE_W-1:0]  rsp_rear_left_drive,
   output logic signed [mwm_pkg::DRIVE_W-1:0]  rsp_front_right_drive,
   output logic signed [mwm_pkg::DRIVE_W-1:0]  rsp_rear_right_drive,
   output logic                                rsp_was_scaled
);

   logic [mwm_pkg::SPEED_W-1:0] top_speed_ff, top_speed_in;
   mwm_pkg::entry_type          front_entry, queue_entry;
   logic                        queue_valid, queue_ready;

   assign top_speed_in = csr_wr_en ? csr_wr_data : top_speed_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         top_speed_ff <= mwm_pkg::TOP_SPEED_RESET;
      end else begin
         top_speed_ff <= top_speed_in;
      end
   end

   mwm_front #(
      .FRAC_BITS (FRAC_BITS)
   ) u_front (
      .forward_rate (req_forward_rate),
      .strafe_rate  (req_strafe_rate),
      .turn_rate    (req_turn_rate),
      .entry        (front_entry)
   );

   mwm_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (req_valid),
      .push_ready (req_ready),
      .push_entry (front_entry),
      .pop_valid  (queue_valid),
      .pop_ready  (queue_ready),
      .pop_entry  (queue_entry)
   );

   mwm_back #(
      .FRAC_BITS (FRAC_BITS)
   ) u_back (
      .clock                 (clock),
      .reset                 (reset),
      .top_speed             (top_speed_ff),
      .item_valid            (queue_valid),
      .item_ready            (queue_ready),
      .item                  (queue_entry),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_front_left_drive  (rsp_front_left_drive),
      .rsp_rear_left_drive   (rsp_rear_left_drive),
      .rsp_front_right_drive (rsp_front_right_drive),
      .rsp_rear_right_drive  (rsp_rear_right_drive),
      .rsp_was_scaled        (rsp_was_scaled)
   );

endmodule

### tb/sv/mecanum_wheel_mixer_core_tb.sv
// Self-checking testbench for mecanum_wheel_mixer_core.
// Uses mwm_pkg for widths and wheel order. Its own mixing model predicts
// each result, and the results are checked in order under random idling.
`timescale 1ns / 1ps

module mecanum_wheel_mixer_core_tb;

   localparam int FRAC_BITS   = 14;
   localparam int MAX_REPORTS = 10;

   typedef struct {
      logic signed [mwm_pkg::DRIVE_W-1:0] drive [mwm_pkg::WHEELS];
      logic                               scaled;
   } wheel_drives_type;

   logic                                clock = 1'b0;
   logic                                reset = 1'b1;
   logic                                csr_wr_en = 1'b0;
   logic [mwm_pkg::SPEED_W-1:0]         csr_wr_data = '0;
   logic                                req_valid = 1'b0;
   logic                                req_ready;
   logic signed [mwm_pkg::RATE_W-1:0]   req_forward_rate = '0;
   logic signed [mwm_pkg::RATE_W-1:0]   req_strafe_rate = '0;
   logic signed [mwm_pkg::RATE_W-1:0]   req_turn_rate = '0;
   logic                                rsp_valid;
   logic                                rsp_ready = 1'b0;
   logic signed [mwm_pkg::DRIVE_W-1:0]  rsp_front_left_drive;
   logic signed [mwm_pkg::DRIVE_W-1:0]  rsp_rear_left_drive;
   logic signed [mwm_pkg::DRIVE_W-1:0]  rsp_front_right_drive;
   logic signed [mwm_pkg::DRIVE_W-1:0]  rsp_rear_right_drive;
   logic                                rsp_was_scaled;

   wheel_drives_type            pending_drives [$];
   logic [mwm_pkg::SPEED_W-1:0] top_speed_setting = mwm_pkg::TOP_SPEED_RESET;
   int                          mismatches = 0;
   int                          tx_idle_pct = 38;
   int                          rx_stall_pct = 49;
   int                          hold_off_requests = 0;
   int                          hold_off_served = 0;
   int                          hold_off_len = 0;

   mecanum_wheel_mixer_core #(.FRAC_BITS(FRAC_BITS)) dut (
      .clock                 (clock),
      .reset                 (reset),
      .csr_wr_en             (csr_wr_en),
      .csr_wr_data           (csr_wr_data),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_forward_rate      (req_forward_rate),
      .req_strafe_rate       (req_strafe_rate),
      .req_turn_rate         (req_turn_rate),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_front_left_drive  (rsp_front_left_drive),
      .rsp_rear_left_drive   (rsp_rear_left_drive),
      .rsp_front_right_drive (rsp_front_right_drive),
      .rsp_rear_right_drive  (rsp_rear_right_drive),
      .rsp_was_scaled        (rsp_was_scaled)
   );

   always #1 clock = ~clock;

   initial begin
      #2000000;
      $display("mecanum_wheel_mixer_core_tb failed");
      $finish;
   end

   // X-drive mix, then normalise by the peak wheel if it exceeds 1.0 and scale
   // to motor units in one exact step, truncating toward zero.
   function automatic wheel_drives_type mix_wheels(
         input logic signed [mwm_pkg::RATE_W-1:0] fwd,
         input logic signed [mwm_pkg::RATE_W-1:0] strafe,
         input logic signed [mwm_pkg::RATE_W-1:0] turn,
         input logic [mwm_pkg::SPEED_W-1:0]       speed);
      wheel_drives_type res;
      longint           wheel [mwm_pkg::WHEELS];
      longint           one;
      longint           peak;
      longint           den;
      longint           mag;
      longint           q;
      one = longint'(1) << FRAC_BITS;
      wheel[mwm_pkg::FL] = longint'(fwd) - longint'(strafe) + longint'(turn);
      wheel[mwm_pkg::RL] = longint'(fwd) + longint'(strafe) + longint'(turn);
      wheel[mwm_pkg::FR] = longint'(fwd) + longint'(strafe) - longint'(turn);
      wheel[mwm_pkg::RR] = longint'(fwd) - longint'(strafe) - longint'(turn);
      peak = 0;
      for (int i = 0; i < mwm_pkg::WHEELS; i++) begin
         mag = (wheel[i] < 0) ? -wheel[i] : wheel[i];
         if (mag > peak) peak = mag;
      end
      res.scaled = (peak > one);
      den = res.scaled ? peak : one;
      for (int i = 0; i < mwm_pkg::WHEELS; i++) begin
         mag = (wheel[i] < 0) ? -wheel[i] : wheel[i];
         q = (mag * longint'(speed)) / den;
         if (wheel[i] < 0) q = -q;
         res.drive[i] = q[mwm_pkg::DRIVE_W-1:0];
      end
      return res;
   endfunction

   // receiver: random stalls, or a long hold-off when one has been asked for
   always @(negedge clock) begin
      if (hold_off_served < hold_off_requests) begin
         rsp_ready <= 1'b0;
         hold_off_len = hold_off_len + 1;
         if (hold_off_len >= 300) begin
            hold_off_served = hold_off_served + 1;
            hold_off_len = 0;
         end
      end else begin
         rsp_ready <= ($urandom_range(99) >= rx_stall_pct);
      end
   end

   task automatic report_mismatch(input string field, input longint want, input longint got);
      mismatches++;
      if (mismatches <= MAX_REPORTS)
         $display("mismatch %0d: %s expected %0d, got %0d", mismatches, field, want, got);
   endtask

   always @(posedge clock) begin
      wheel_drives_type want;
      wheel_drives_type got;
      string            wheel_name [mwm_pkg::WHEELS];
      wheel_name[mwm_pkg::FL] = "front_left_drive";
      wheel_name[mwm_pkg::RL] = "rear_left_drive";
      wheel_name[mwm_pkg::FR] = "front_right_drive";
      wheel_name[mwm_pkg::RR] = "rear_right_drive";
      if (!reset && rsp_valid && rsp_ready) begin
         got.drive[mwm_pkg::FL] = rsp_front_left_drive;
         got.drive[mwm_pkg::RL] = rsp_rear_left_drive;
         got.drive[mwm_pkg::FR] = rsp_front_right_drive;
         got.drive[mwm_pkg::RR] = rsp_rear_right_drive;
         got.scaled = rsp_was_scaled;
         if (pending_drives.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("mismatch %0d: result with no item outstanding", mismatches);
         end else begin
            want = pending_drives.pop_front();
            for (int i = 0; i < mwm_pkg::WHEELS; i++)
               if (got.drive[i] !== want.drive[i])
                  report_mismatch(wheel_name[i], longint'(want.drive[i]),
                                  longint'(got.drive[i]));
            if (got.scaled !== want.scaled)
               report_mismatch("was_scaled", longint'(want.scaled), longint'(got.scaled));
         end
      end
   end

   task automatic send_command(input logic signed [mwm_pkg::RATE_W-1:0] fwd,
                               input logic signed [mwm_pkg::RATE_W-1:0] strafe,
                               input logic signed [mwm_pkg::RATE_W-1:0] turn);
      @(negedge clock);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         req_forward_rate <= 16'($urandom);
         req_strafe_rate <= 16'($urandom);
         req_turn_rate <= 16'($urandom);
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_forward_rate <= fwd;
      req_strafe_rate <= strafe;
      req_turn_rate <= turn;
      do @(posedge clock); while (!req_ready);
      pending_drives.push_back(mix_wheels(fwd, strafe, turn, top_speed_setting));
   endtask

   task automatic drain_pipeline();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_drives.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_top_speed(input logic [mwm_pkg::SPEED_W-1:0] speed);
      drain_pipeline();
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= speed;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      csr_wr_data <= 16'($urandom);
      top_speed_setting = speed;
   endtask

   // full-range commands, plus smaller ones, corner values and ones hovering
   // around the full-scale boundary
   task automatic random_commands(input int count);
      int                                kind;
      logic signed [mwm_pkg::RATE_W-1:0] rate [3];
      logic signed [mwm_pkg::RATE_W-1:0] corner [7];
      corner = '{16'sh7FFF, -16'sh8000, 16'sd0, 16'sd1, -16'sd1, 16'sd16384, -16'sd16384};
      for (int n = 0; n < count; n++) begin
         kind = int'($urandom_range(99));
         for (int k = 0; k < 3; k++) begin
            if (kind < 40)
               rate[k] = 16'($urandom);
            else if (kind < 70)
               rate[k] = 16'(int'($urandom_range(16383)) - 8192);
            else if (kind < 85)
               rate[k] = (k == 0) ? 16'(16384 + int'($urandom_range(8)) - 4)
                                  : 16'(int'($urandom_range(4)) - 2);
            else
               rate[k] = corner[$urandom_range(6)];
         end
         if (kind >= 70 && kind < 85 && $urandom_range(1)) rate[0] = -rate[0];
         send_command(rate[0], rate[1], rate[2]);
      end
   endtask

   task automatic test_extreme_commands();
      send_command(16'sd0, 16'sd0, 16'sd0);
      send_command(16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
      send_command(-16'sh8000, -16'sh8000, -16'sh8000);
      send_command(16'sh7FFF, -16'sh8000, 16'sh7FFF);
      send_command(-16'sh8000, 16'sh7FFF, -16'sh8000);
      send_command(16'sd1, 16'sd0, 16'sd0);
      send_command(-16'sd1, -16'sd1, -16'sd1);
      send_command(16'sd0, 16'sh7FFF, 16'sd0);
      send_command(16'sd0, 16'sd0, -16'sh8000);
   endtask

   // peak exactly 1.0 must not scale; one LSB above must
   task automatic test_full_scale_edge();
      send_command(16'sd16384, 16'sd0, 16'sd0);
      send_command(-16'sd16384, 16'sd0, 16'sd0);
      send_command(16'sd0, 16'sd0, 16'sd16384);
      send_command(16'sd8192, 16'sd4096, 16'sd4096);
      send_command(16'sd16385, 16'sd0, 16'sd0);
      send_command(16'sd8192, 16'sd4096, 16'sd4097);
   endtask

   task automatic test_zero_speed();
      write_top_speed(16'd0);
      send_command(16'sh7FFF, 16'sd0, 16'sd0);
      send_command(16'sd100, -16'sd200, 16'sd300);
      send_command(16'sd0, 16'sd0, 16'sd0);
   endtask

   task automatic test_speed_extremes();
      write_top_speed(16'hFFFF);
      send_command(16'sd16384, 16'sd0, 16'sd0);
      send_command(-16'sd12345, 16'sd6789, -16'sd1);
      send_command(16'sh7FFF, -16'sd1, 16'sd1);
      write_top_speed(16'd1);
      send_command(16'sd16383, 16'sd0, 16'sd0);
      send_command(-16'sd16384, 16'sd0, 16'sd0);
   endtask

   // receiver holds off while items keep coming, so the input must stall
   task automatic test_backpressure();
      int saved_idle;
      saved_idle = tx_idle_pct;
      tx_idle_pct = 0;
      hold_off_requests = hold_off_requests + 1;
      random_commands(12);
      tx_idle_pct = saved_idle;
      drain_pipeline();
   endtask

   task automatic test_random_traffic(input int count,
                                      input logic [mwm_pkg::SPEED_W-1:0] speed);
      write_top_speed(speed);
      random_commands(count);
   endtask

   initial begin
      repeat (5) @(negedge clock);
      reset <= 1'b0;

      test_extreme_commands();
      test_full_scale_edge();
      test_zero_speed();
      test_speed_extremes();
      test_random_traffic(300, 16'($urandom));
      test_backpressure();

      tx_idle_pct = 49;
      rx_stall_pct = 38;
      test_random_traffic(250, mwm_pkg::TOP_SPEED_RESET);
      test_backpressure();

      tx_idle_pct = 0;
      rx_stall_pct = 0;
      test_random_traffic(140, 16'hFFFF);
      test_random_traffic(140, 16'($urandom_range(300, 1)));

      drain_pipeline();
      repeat (40) @(posedge clock);
      if (mismatches == 0 && pending_drives.size() == 0)
         $display("mecanum_wheel_mixer_core_tb passed");
      else
         $display("mecanum_wheel_mixer_core_tb failed");
      $finish;
   end

endmodule
